// ===== hdl/lmt_pkg.sv =====
// Shared types, mode codes and default timing constants for the LCD line and mode timing block.
package lmt_pkg;

  localparam int LINE_CYCLES_DEF     = 456;
  localparam int OAM_CYCLES_DEF      = 80;
  localparam int TRANSFER_CYCLES_DEF = 172;
  localparam int VISIBLE_LINES_DEF   = 144;
  localparam int LAST_LINE_DEF       = 153;

  localparam int CountW = 10;

  // Bit positions in irq_enable_bits
  localparam int EN_HBLANK = 0;
  localparam int EN_VBLANK = 1;
  localparam int EN_OAM    = 2;
  localparam int EN_COINC  = 3;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_OAM      = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] cycles;
    logic       lcd_enable;
    logic [7:0] line_compare;
    logic [3:0] irq_enable_bits;
  } item_t;

  typedef struct packed {
    logic [7:0] line_number;
    logic [1:0] lcd_mode;
    logic       coincidence_flag;
    logic       stat_irq;
    logic       vblank_irq;
    logic       draw_line;
    logic [7:0] draw_line_index;
  } result_t;

  typedef struct packed {
    logic signed [CountW-1:0] countdown;
    logic [7:0]               line;
    mode_t                    mode;
    logic                     coinc;
  } timing_state_t;

endpackage

// ===== hdl/lmt_step.sv =====
// Next-state and result logic for one timing step.
module lmt_step import lmt_pkg::*; #(
  parameter int LINE_CYCLES     = LINE_CYCLES_DEF,
  parameter int OAM_CYCLES      = OAM_CYCLES_DEF,
  parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF,
  parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
  parameter int LAST_LINE       = LAST_LINE_DEF
) (
  input  item_t         item,
  input  timing_state_t cur,
  output timing_state_t nxt,
  output result_t       res
);

  localparam logic signed [CountW:0] LineCnt   = (CountW+1)'(LINE_CYCLES);
  localparam logic signed [CountW:0] BoundOam  = (CountW+1)'(LINE_CYCLES - OAM_CYCLES);
  localparam logic signed [CountW:0] BoundXfer =
    (CountW+1)'(LINE_CYCLES - OAM_CYCLES - TRANSFER_CYCLES);
  localparam logic [7:0] VisLine  = 8'(VISIBLE_LINES);
  localparam logic [7:0] LastLine = 8'(LAST_LINE);

  logic signed [CountW:0] cd_sub;
  logic signed [CountW:0] cd_reload;
  mode_t                  mode;
  logic                   want_irq;
  logic                   line_match;
  logic [7:0]             line_inc;

  always_comb begin
    cd_sub    = $signed({cur.countdown[CountW-1], cur.countdown})
              - $signed({3'b000, item.cycles});
    cd_reload = cd_sub + LineCnt;
    line_inc  = cur.line + 8'd1;
    line_match = (cur.line == item.line_compare);

    // mode comes from the line held before any advance
    if (cur.line >= VisLine) begin
      mode     = MODE_VBLANK;
      want_irq = item.irq_enable_bits[EN_VBLANK];
    end else if (cd_sub > BoundOam) begin
      mode     = MODE_OAM;
      want_irq = item.irq_enable_bits[EN_OAM];
    end else if (cd_sub > BoundXfer) begin
      mode     = MODE_TRANSFER;
      want_irq = 1'b0;
    end else begin
      mode     = MODE_HBLANK;
      want_irq = item.irq_enable_bits[EN_HBLANK];
    end

    nxt = cur;
    res = '0;

    if (!item.lcd_enable) begin
      nxt.countdown        = LineCnt[CountW-1:0];
      nxt.line             = 8'd0;
      nxt.mode             = MODE_VBLANK;
      res.line_number      = 8'd0;
      res.lcd_mode         = MODE_VBLANK;
      res.coincidence_flag = cur.coinc;
    end else begin
      nxt.mode  = mode;
      nxt.coinc = line_match;
      nxt.countdown = cd_sub[CountW-1:0];
      nxt.line  = cur.line;

      res.stat_irq = (want_irq && (cur.mode != mode))
                   || (line_match && item.irq_enable_bits[EN_COINC]);

      if ((mode == MODE_HBLANK) && (cur.mode != mode) && (cur.line < VisLine)) begin
        res.draw_line       = 1'b1;
        res.draw_line_index = cur.line;
      end

      // line done: advance and keep the excess
      if (cd_sub[CountW] || (cd_sub == '0)) begin
        nxt.countdown = cd_reload[CountW-1:0];
        if (line_inc == VisLine) begin
          nxt.line       = line_inc;
          res.vblank_irq = 1'b1;
        end else if (line_inc > LastLine) begin
          nxt.line = 8'd0;
        end else begin
          nxt.line = line_inc;
        end
      end

      res.line_number      = nxt.line;
      res.lcd_mode         = mode;
      res.coincidence_flag = line_match;
    end
  end

endmodule

// ===== hdl/lcd_line_and_mode_timing.sv =====
// Top level: input register, timing state, step logic and result register.
//
// LCD line and mode timing. Each beat on the item channel carries the cycles
// elapsed since the last beat, the display enable bit, the LY compare value
// and the four STAT interrupt enables. Each item yields exactly one beat on
// the result channel: LY after the step, the mode, the coincidence flag, the
// STAT and vblank interrupt pulses and the draw-line pulse with its line.
// Both channels use valid/ready; a beat moves when both are high.
// An accepted item is taken into the input register, passes through the step
// logic and is then captured by the result register, which raises result_valid.
// Throughput: one item per cycle while the receiver takes results; the only loop
// is the update of the line countdown, line, mode and coincidence registers.
// Reset (rst, synchronous) empties both registers and loads the countdown
// with LINE_CYCLES, line 0, mode hblank and a clear coincidence bit.
// When the receiver stalls, the result register holds, the input register
// keeps its item, and item_ready drops once both are full; no beat is lost.
module lcd_line_and_mode_timing import lmt_pkg::*; #(
  parameter int LINE_CYCLES     = LINE_CYCLES_DEF,
  parameter int OAM_CYCLES      = OAM_CYCLES_DEF,
  parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF,
  parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
  parameter int LAST_LINE       = LAST_LINE_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic          held_valid;
  item_t         held;
  logic          advance;
  timing_state_t state;
  timing_state_t state_next;
  result_t       step_res;

  assign advance    = !result_valid || result_ready;
  assign item_ready = !held_valid || advance;

  lmt_step #(
    .LINE_CYCLES     (LINE_CYCLES),
    .OAM_CYCLES      (OAM_CYCLES),
    .TRANSFER_CYCLES (TRANSFER_CYCLES),
    .VISIBLE_LINES   (VISIBLE_LINES),
    .LAST_LINE       (LAST_LINE)
  ) u_step (
    .item (held),
    .cur  (state),
    .nxt  (state_next),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.countdown <= CountW'(LINE_CYCLES);
      state.line      <= 8'd0;
      state.mode      <= MODE_HBLANK;
      state.coinc     <= 1'b0;
      result_valid    <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
      if (held_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid) begin
      result <= step_res;
    end
  end

  // Countdown is reloaded on every underflow, so it stays positive.
  assert property (@(posedge clk) disable iff (rst)
    (state.countdown > 0) && (state.countdown <= CountW'(LINE_CYCLES)))
    else $error("line countdown out of range");

  assert property (@(posedge clk) disable iff (rst)
    state.line <= 8'(LAST_LINE))
    else $error("line counter past last line");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.draw_line |->
      (result.lcd_mode == MODE_HBLANK) && (result.draw_line_index < 8'(VISIBLE_LINES)))
    else $error("draw pulse outside visible hblank");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.vblank_irq |-> (result.line_number == 8'(VISIBLE_LINES)))
    else $error("vblank interrupt on wrong line");

  assert property (@(posedge clk) disable iff (rst)
    held_valid && advance |=> result_valid)
    else $error("held item did not reach result register");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LCD line and mode timing block.
module tb_top;
  import lmt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_STEPS = 600;
  localparam int HOLD_AT      = 300;  // result count at which the receiver holds off
  localparam int HOLD_LEN     = 80;
  localparam int DRAIN_CYCLES = 8;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  lcd_line_and_mode_timing u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  item_t   lcd_steps[$];        // steps waiting to be offered
  result_t expected_timing[$];  // predicted beats not yet seen
  logic    calm = 1'b0;         // no idling on either side while set
  int      mismatches = 0;
  int      results_seen = 0;
  int      hold_left = 0;
  logic    hold_done = 1'b0;
  int      cycle_count = 0;
  result_t want;

  // Predicted timing state
  int         line_cd;
  logic [7:0] ly;
  mode_t      ppu_mode;
  logic       ly_match;

  function automatic result_t advance_line_timing(input item_t it);
    result_t    r;
    mode_t      next_mode;
    logic [7:0] start_line;
    logic [7:0] next_line;
    logic       mode_irq_en;
    int         oam_edge;
    int         xfer_edge;
    r           = '0;
    start_line  = ly;
    mode_irq_en = 1'b0;
    next_mode   = MODE_HBLANK;
    oam_edge    = LINE_CYCLES_DEF - OAM_CYCLES_DEF;
    xfer_edge   = oam_edge - TRANSFER_CYCLES_DEF;
    line_cd     = line_cd - int'(it.cycles);
    if (!it.lcd_enable) begin
      line_cd  = LINE_CYCLES_DEF;
      ly       = '0;
      ppu_mode = MODE_VBLANK;
    end else begin
      if (int'(start_line) >= VISIBLE_LINES_DEF) begin
        next_mode   = MODE_VBLANK;
        mode_irq_en = it.irq_enable_bits[EN_VBLANK];
      end else if (line_cd > oam_edge) begin
        next_mode   = MODE_OAM;
        mode_irq_en = it.irq_enable_bits[EN_OAM];
      end else if (line_cd > xfer_edge) begin
        next_mode = MODE_TRANSFER;
      end else begin
        next_mode   = MODE_HBLANK;
        mode_irq_en = it.irq_enable_bits[EN_HBLANK];
      end
      if (mode_irq_en && ppu_mode != next_mode) r.stat_irq = 1'b1;
      ly_match = (start_line == it.line_compare);
      if (ly_match && it.irq_enable_bits[EN_COINC]) r.stat_irq = 1'b1;
      // draw pulse on first entry to hblank of a visible line
      if (next_mode == MODE_HBLANK && ppu_mode != next_mode &&
          int'(start_line) < VISIBLE_LINES_DEF) begin
        r.draw_line       = 1'b1;
        r.draw_line_index = start_line;
      end
      ppu_mode  = next_mode;
      next_line = start_line;
      if (line_cd <= 0) begin
        next_line = start_line + 8'd1;
        line_cd   = line_cd + LINE_CYCLES_DEF;
        if (int'(next_line) == VISIBLE_LINES_DEF) r.vblank_irq = 1'b1;
        else if (int'(next_line) > LAST_LINE_DEF) next_line = '0;
      end
      ly = next_line;
    end
    r.line_number      = ly;
    r.lcd_mode         = ppu_mode;
    r.coincidence_flag = ly_match;
    return r;
  endfunction

  task automatic push_step(input int cyc, input bit en, input int cmp, input int irq);
    item_t s;
    s.cycles          = 8'(cyc);
    s.lcd_enable      = en;
    s.line_compare    = 8'(cmp);
    s.irq_enable_bits = 4'(irq);
    lcd_steps.push_back(s);
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // Driver: offer the next step, with random idle gaps, once the current beat is gone
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (item_valid) expected_timing.push_back(advance_line_timing(item));
      if (lcd_steps.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
        item       <= lcd_steps.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat and drive result_ready
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_timing.size() == 0) begin
          $error("unexpected result beat: line_number %0d", result.line_number);
          mismatches++;
        end else begin
          want = expected_timing.pop_front();
          check_field("line_number", want.line_number, result.line_number);
          check_field("lcd_mode", want.lcd_mode, result.lcd_mode);
          check_field("coincidence_flag", want.coincidence_flag, result.coincidence_flag);
          check_field("stat_irq", want.stat_irq, result.stat_irq);
          check_field("vblank_irq", want.vblank_irq, result.vblank_irq);
          check_field("draw_line", want.draw_line, result.draw_line);
          check_field("draw_line_index", want.draw_line_index, result.draw_line_index);
        end
        results_seen++;
      end
      // hold off once for a long stretch so the block backs up its input
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int   cyc;
    int   cmp;
    int   pick;
    bit   en;
    line_cd  = LINE_CYCLES_DEF;
    ly       = '0;
    ppu_mode = MODE_HBLANK;
    ly_match = 1'b0;

    // Directed: display off, mode window edges, line advance with excess
    push_step(255, 1'b0, 255, 15);
    push_step(0,   1'b1, 0,   15);
    push_step(75,  1'b1, 0,   4);
    push_step(1,   1'b1, 0,   4);
    push_step(1,   1'b1, 0,   15);
    push_step(171, 1'b1, 0,   1);
    push_step(1,   1'b1, 0,   1);
    push_step(204, 1'b1, 1,   8);
    push_step(255, 1'b1, 255, 0);
    push_step(255, 1'b1, 2,   15);
    push_step(0,   1'b1, 2,   15);
    push_step(100, 1'b1, 3,   6);
    push_step(255, 1'b1, 3,   9);
    push_step(255, 1'b1, 4,   15);
    push_step(100, 1'b0, 0,   15);
    push_step(0,   1'b0, 0,   15);
    push_step(255, 1'b1, 0,   15);
    push_step(255, 1'b1, 255, 10);
    push_step(200, 1'b1, 1,   5);
    push_step(0,   1'b1, 128, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < RANDOM_STEPS; i++) begin
      calm = (i >= 100 && i < 200);
      // sender pause: drain everything once
      if (i == 420) begin
        while (lcd_steps.size() != 0 || item_valid || expected_timing.size() != 0)
          @(posedge clk);
      end
      while (lcd_steps.size() >= 2) @(posedge clk);
      // mostly long steps so whole frames pass; some short ones hit every window
      if ($urandom_range(99) < 60) cyc = $urandom_range(255, 180);
      else cyc = $urandom_range(255);
      // aim the compare value at the current line often
      pick = $urandom_range(99);
      if (pick < 40) cmp = ly;
      else if (pick < 60) cmp = ly + 1;
      else cmp = $urandom_range(255);
      // display off only in one late burst and as rare noise
      en = !((i >= 560 && i < 564) || $urandom_range(999) == 0);
      push_step(cyc, en, cmp, $urandom_range(15));
    end
    calm = 1'b0;

    while (lcd_steps.size() != 0 || item_valid || expected_timing.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
